/* rtl/ppu_pkg.sv */
// ---------------------------------------------------------------------------
// ppu_pkg: shared types and constants for the particle pool update block
// Field widths, item codes and fixed-point rounding constants.
// ---------------------------------------------------------------------------
package ppu_pkg;

    // Field widths of the input and result items.
    localparam int FIX_W      = 32;
    localparam int JIT_W      = 16;
    localparam int VAR_W      = 16;
    localparam int DUR_W      = 31;
    localparam int SLOT_OUT_W = 6;
    localparam int S_TDATA_W  = 288;
    localparam int M_TDATA_W  = 104;

    // Width of a product of the shared multiplier and of its operands.
    localparam int MUL_OP_W   = 33;
    localparam int PROD_W     = 64;

    // Rounding: the jitter product drops 7 fraction bits, the step product 16.
    localparam int EMIT_SHIFT = 7;
    localparam int TICK_SHIFT = 16;

    // Kind of an input item, carried in s_tuser.
    typedef enum logic {
        ACT_EMIT = 1'b0,
        ACT_TICK = 1'b1
    } action_t;

    // Index of an axis inside the three-component vectors.
    typedef logic [1:0] axis_t;
    localparam axis_t AXIS_LAST = 2'd2;

    typedef logic signed [FIX_W-1:0] fix_t;

endpackage

/* rtl/particle_pool_update.sv */
// ---------------------------------------------------------------------------
// particle_pool_update: ring pool of particles with Euler updates
// Emit items write one slot at a descending cursor; tick items walk the whole
// pool, age every active slot and move the ones that survive.
//
//  channel  | direction | tdata fields (low bit up)                 | tuser  | tlast
//  s_       | in        | pos_x/y/z, vel_x/y/z, jitter_x/y/z,      | action | -
//           |           | variation, duration                       |        |
//  m_       | out       | slot, out_x, out_y, out_z                 | alive  | last
//
// An emit item makes three passes of the shared multiplier and accumulator,
// one per axis, then writes the slot. A tick item gives one result per slot;
// a live slot goes through read, aging, three multiply-accumulate axis passes,
// write and output, an inactive or dying one through read, aging and output,
// and each output can be held by an m_tready stall.
// s_tready is high only while the block is idle. Reset clears all active
// flags and puts the cursor on the top slot; the slot stores need no clearing.
// ---------------------------------------------------------------------------
module particle_pool_update #(
    parameter int POOL_SIZE = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, jitter_x, jitter_y,
    // jitter_z, variation, duration, zero fill
    input  logic [ppu_pkg::S_TDATA_W-1:0]  s_tdata,
    // action
    input  logic                            s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // slot, out_x, out_y, out_z, zero fill
    output logic [ppu_pkg::M_TDATA_W-1:0]  m_tdata,
    // alive
    output logic                            m_tuser,
    output logic                            m_tlast
);

    localparam int SLOT_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(POOL_SIZE - 1);
    localparam int FW = ppu_pkg::FIX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_LIFE,
        S_MUL,
        S_ACC,
        S_WR,
        S_OUT
    } state_t;

    state_t state_reg;

    // Latched input item.
    ppu_pkg::action_t               act_reg;
    ppu_pkg::fix_t                  in_pos_reg [3];
    ppu_pkg::fix_t                  in_vel_reg [3];
    logic signed [ppu_pkg::JIT_W-1:0] in_jit_reg [3];
    logic [ppu_pkg::VAR_W-1:0]      in_var_reg;
    logic [ppu_pkg::DUR_W-1:0]      in_dur_reg;

    // Sequencer and working registers.
    logic [SLOT_W-1:0]              slot_reg;
    logic [SLOT_W-1:0]              next_slot_reg;
    ppu_pkg::axis_t                 axis_reg;
    logic [POOL_SIZE-1:0]           active_reg;
    ppu_pkg::fix_t                  pos_w_reg [3];
    ppu_pkg::fix_t                  vel_w_reg [3];
    ppu_pkg::fix_t                  res_reg [3];
    logic signed [ppu_pkg::PROD_W-1:0] prod_reg;

    // Result registers.
    logic                           m_tvalid_reg;
    logic [ppu_pkg::M_TDATA_W-1:0]  m_tdata_reg;
    logic                           m_tuser_reg;
    logic                           m_tlast_reg;

    // Slot stores, each word packed z, y, x from the top.
    logic [3*FW-1:0]                pos_mem [POOL_SIZE];
    logic [3*FW-1:0]                vel_mem [POOL_SIZE];
    logic [FW-1:0]                  life_mem [POOL_SIZE];
    logic [3*FW-1:0]                pos_rd_reg;
    logic [3*FW-1:0]                vel_rd_reg;
    logic signed [FW-1:0]           life_rd_reg;

    logic                           s_fire;
    logic                           is_emit;
    logic                           slot_active;

    assign s_tready    = (state_reg == S_IDLE);
    assign s_fire      = s_tvalid && s_tready;
    assign is_emit     = (act_reg == ppu_pkg::ACT_EMIT);
    assign slot_active = active_reg[slot_reg];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // Remaining life after this tick's step.
    logic signed [FW:0] life_diff;
    logic               life_over;

    assign life_diff = {life_rd_reg[FW-1], life_rd_reg} - {2'b00, in_dur_reg};
    assign life_over = life_diff[FW] || (life_diff == '0);

    // Shared multiplier: jitter times variation on emit, velocity times step on tick.
    logic signed [ppu_pkg::MUL_OP_W-1:0]   mul_a;
    logic signed [ppu_pkg::MUL_OP_W-1:0]   mul_b;
    logic signed [2*ppu_pkg::MUL_OP_W-1:0] mul_full;

    always_comb begin
        if (is_emit) begin
            mul_a = {{(ppu_pkg::MUL_OP_W - ppu_pkg::JIT_W){in_jit_reg[axis_reg][ppu_pkg::JIT_W-1]}},
                     in_jit_reg[axis_reg]};
            mul_b = {{(ppu_pkg::MUL_OP_W - ppu_pkg::VAR_W){1'b0}}, in_var_reg};
        end else begin
            mul_a = {vel_w_reg[axis_reg][FW-1], vel_w_reg[axis_reg]};
            mul_b = {{(ppu_pkg::MUL_OP_W - ppu_pkg::DUR_W){1'b0}}, in_dur_reg};
        end
    end

    assign mul_full = mul_a * mul_b;

    // Shared accumulator: round half up, add to the base and saturate.
    logic signed [ppu_pkg::PROD_W:0]   prod_ext;
    logic signed [ppu_pkg::PROD_W:0]   rnd_sum;
    logic signed [ppu_pkg::PROD_W:0]   rnd_val;
    ppu_pkg::fix_t                     acc_base;
    logic signed [ppu_pkg::PROD_W+1:0] acc_sum;
    ppu_pkg::fix_t                     acc_sat;

    assign prod_ext = {prod_reg[ppu_pkg::PROD_W-1], prod_reg};

    always_comb begin
        if (is_emit) begin
            rnd_sum  = prod_ext + (ppu_pkg::PROD_W+1)'(1 << (ppu_pkg::EMIT_SHIFT - 1));
            rnd_val  = rnd_sum >>> ppu_pkg::EMIT_SHIFT;
            acc_base = in_vel_reg[axis_reg];
        end else begin
            rnd_sum  = prod_ext + (ppu_pkg::PROD_W+1)'(1 << (ppu_pkg::TICK_SHIFT - 1));
            rnd_val  = rnd_sum >>> ppu_pkg::TICK_SHIFT;
            acc_base = pos_w_reg[axis_reg];
        end
        acc_sum = {{(ppu_pkg::PROD_W + 2 - FW){acc_base[FW-1]}}, acc_base}
                + {rnd_val[ppu_pkg::PROD_W], rnd_val};
        // Out of range when the bits above the sign do not all match it.
        if (acc_sum[ppu_pkg::PROD_W+1:FW-1] == '0 || acc_sum[ppu_pkg::PROD_W+1:FW-1] == '1) begin
            acc_sat = acc_sum[FW-1:0];
        end else if (acc_sum[ppu_pkg::PROD_W+1]) begin
            acc_sat = {1'b1, {(FW-1){1'b0}}};
        end else begin
            acc_sat = {1'b0, {(FW-1){1'b1}}};
        end
    end

    // Store write controls; every access goes to the slot under the sequencer.
    logic            pos_we;
    logic            vel_we;
    logic            life_we;
    logic [3*FW-1:0] pos_wdata;
    logic [FW-1:0]   life_wdata;

    assign pos_we     = (state_reg == S_WR);
    assign vel_we     = (state_reg == S_WR) && is_emit;
    assign life_we    = vel_we || ((state_reg == S_LIFE) && !is_emit && slot_active);
    assign pos_wdata  = is_emit ? {in_pos_reg[2], in_pos_reg[1], in_pos_reg[0]}
                                : {res_reg[2], res_reg[1], res_reg[0]};
    assign life_wdata = is_emit ? {1'b0, in_dur_reg} : life_diff[FW-1:0];

    // Slot stores with registered reads.
    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[slot_reg] <= pos_wdata;
        end
        if (vel_we) begin
            vel_mem[slot_reg] <= {res_reg[2], res_reg[1], res_reg[0]};
        end
        if (life_we) begin
            life_mem[slot_reg] <= life_wdata;
        end
        pos_rd_reg  <= pos_mem[slot_reg];
        vel_rd_reg  <= vel_mem[slot_reg];
        life_rd_reg <= life_mem[slot_reg];
    end

    // Sequencer, working registers and result registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            next_slot_reg <= SLOT_LAST;
            active_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
            slot_reg      <= '0;
            axis_reg      <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        act_reg <= ppu_pkg::action_t'(s_tuser);
                        for (int a = 0; a < 3; a++) begin
                            in_pos_reg[a] <= s_tdata[a*FW +: FW];
                            in_vel_reg[a] <= s_tdata[(3+a)*FW +: FW];
                            in_jit_reg[a] <= s_tdata[6*FW + a*ppu_pkg::JIT_W +: ppu_pkg::JIT_W];
                        end
                        in_var_reg <= s_tdata[6*FW + 3*ppu_pkg::JIT_W +: ppu_pkg::VAR_W];
                        in_dur_reg <= s_tdata[6*FW + 3*ppu_pkg::JIT_W + ppu_pkg::VAR_W +:
                                              ppu_pkg::DUR_W];
                        axis_reg   <= '0;
                        if (s_tuser == ppu_pkg::ACT_EMIT) begin
                            slot_reg  <= next_slot_reg;
                            state_reg <= S_MUL;
                        end else begin
                            slot_reg  <= '0;
                            state_reg <= S_RD;
                        end
                    end
                end

                // Read data for the slot lands in the read registers.
                S_RD: begin
                    state_reg <= S_LIFE;
                end

                // Age the slot; dead and idle slots report at once.
                S_LIFE: begin
                    m_tdata_reg <= {{(ppu_pkg::M_TDATA_W - ppu_pkg::SLOT_OUT_W){1'b0}},
                                    ppu_pkg::SLOT_OUT_W'(slot_reg)};
                    m_tuser_reg <= 1'b0;
                    m_tlast_reg <= (slot_reg == SLOT_LAST);
                    if (slot_active && !life_over) begin
                        for (int a = 0; a < 3; a++) begin
                            pos_w_reg[a] <= pos_rd_reg[a*FW +: FW];
                            vel_w_reg[a] <= vel_rd_reg[a*FW +: FW];
                        end
                        axis_reg  <= '0;
                        state_reg <= S_MUL;
                    end else begin
                        if (slot_active) begin
                            active_reg[slot_reg] <= 1'b0;
                        end
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_OUT;
                    end
                end

                S_MUL: begin
                    prod_reg  <= mul_full[ppu_pkg::PROD_W-1:0];
                    state_reg <= S_ACC;
                end

                S_ACC: begin
                    res_reg[axis_reg] <= acc_sat;
                    if (axis_reg == ppu_pkg::AXIS_LAST) begin
                        state_reg <= S_WR;
                    end else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end

                // Stores take the new slot contents; a tick also shows the result.
                S_WR: begin
                    if (is_emit) begin
                        active_reg[slot_reg] <= 1'b1;
                        next_slot_reg <= (slot_reg == '0) ? SLOT_LAST : slot_reg - 1'b1;
                        state_reg     <= S_IDLE;
                    end else begin
                        m_tdata_reg <= {2'b00, res_reg[2], res_reg[1], res_reg[0],
                                        ppu_pkg::SLOT_OUT_W'(slot_reg)};
                        m_tuser_reg  <= 1'b1;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_OUT;
                    end
                end

                S_OUT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        if (slot_reg == SLOT_LAST) begin
                            state_reg <= S_IDLE;
                        end else begin
                            slot_reg  <= slot_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The block never takes an item while a result is on offer.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted while a result is pending");

    // A slot that is not alive reports a zero position.
    a_dead_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[101:6] == '0))
        else $error("dead slot reports a nonzero position");

    // The last result of a tick belongs to the top slot.
    a_last_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[5:0] == ppu_pkg::SLOT_OUT_W'(POOL_SIZE - 1)))
        else $error("last flag on a slot other than the top one");

    // Once the final result is taken, the block is ready for a new item.
    a_end_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("block not idle after the final result of a tick");

endmodule
